// ===== hdl/sri_pkg.sv =====
// Shared widths and types for the segment/rectangle intersection core.
// No dependencies; every other file in hdl/ refers to this package by scoped names.
package sri_pkg;

    // Coordinate width of the ports; sizes are one bit narrower and unsigned.
    localparam int COORD_WIDTH = 16;
    localparam int SIZE_WIDTH  = COORD_WIDTH - 1;
    // Differences such as x1 - left - width need two bits above the coordinate.
    localparam int DIFF_WIDTH  = COORD_WIDTH + 2;
    localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;
    localparam int TERM_WIDTH  = PROD_WIDTH + 1;
    localparam int NUM_EDGES   = 4;
    localparam int PIPE_DEPTH  = 4;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic        [SIZE_WIDTH-1:0]  size_t;
    typedef logic signed [DIFF_WIDTH-1:0]  diff_t;
    typedef logic signed [PROD_WIDTH-1:0]  prod_t;
    typedef logic signed [TERM_WIDTH-1:0]  term_t;

    // Operands of one edge test. den = len * a, na = -(len * b),
    // nb = sx * oy - sy * ox.
    typedef struct packed {
        diff_t len;
        diff_t a;
        diff_t b;
        diff_t sx;
        diff_t sy;
        diff_t ox;
        diff_t oy;
    } edge_op_t;

endpackage

// ===== hdl/segment_rect_intersect_core.sv =====
// Throughput: one item per cycle; four pipeline stages (differences, products,
// numerators, compare) move together and all hold while the result waits.
// Reset: aresetn is synchronous and active low; it clears the stage valid bits,
// and s_ready stays low while reset is held.
// Top level of the segment/rectangle intersection core. Depends on sri_pkg and
// sri_edge_unit.
module segment_rect_intersect_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  sri_pkg::coord_t      s_seg_start_x,
    input  sri_pkg::coord_t      s_seg_start_y,
    input  sri_pkg::coord_t      s_seg_end_x,
    input  sri_pkg::coord_t      s_seg_end_y,
    input  sri_pkg::coord_t      s_rect_left,
    input  sri_pkg::coord_t      s_rect_top,
    input  sri_pkg::size_t       s_rect_width,
    input  sri_pkg::size_t       s_rect_height,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_hit
);

    logic [sri_pkg::PIPE_DEPTH-1:0] valid_reg;
    logic [sri_pkg::PIPE_DEPTH-1:0] valid_next;
    logic                           advance;
    sri_pkg::edge_op_t              edge_op_next [sri_pkg::NUM_EDGES];
    sri_pkg::edge_op_t              edge_op_reg  [sri_pkg::NUM_EDGES];
    logic [sri_pkg::NUM_EDGES-1:0]  edge_hit;
    logic                           hit_reg;

    sri_pkg::diff_t x1, y1, x2, y2, left, top, width, height;
    sri_pkg::diff_t sx, sy, ox_left, ox_right, oy_top, oy_bottom;

    // The whole pipeline moves when the output register is empty or being taken.
    assign advance = !valid_reg[sri_pkg::PIPE_DEPTH-1] || m_ready;
    assign s_ready = aresetn && advance;
    assign m_valid = valid_reg[sri_pkg::PIPE_DEPTH-1];
    assign m_hit   = hit_reg;

    // Valid bits travel alongside the data.
    always_comb begin
        valid_next = {valid_reg[sri_pkg::PIPE_DEPTH-2:0], s_valid};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (advance) begin
            valid_reg <= valid_next;
        end
    end

    // Stage 1: widen the fields and form every difference the edges need.
    always_comb begin
        x1        = sri_pkg::diff_t'(s_seg_start_x);
        y1        = sri_pkg::diff_t'(s_seg_start_y);
        x2        = sri_pkg::diff_t'(s_seg_end_x);
        y2        = sri_pkg::diff_t'(s_seg_end_y);
        left      = sri_pkg::diff_t'(s_rect_left);
        top       = sri_pkg::diff_t'(s_rect_top);
        width     = sri_pkg::diff_t'(s_rect_width);
        height    = sri_pkg::diff_t'(s_rect_height);
        sx        = x2 - x1;
        sy        = y2 - y1;
        ox_left   = x1 - left;
        ox_right  = x1 - left - width;
        oy_top    = y1 - top;
        oy_bottom = y1 - top - height;

        // Left and right edges run along y; their length is the height.
        edge_op_next[0] = '{len: height, a: sx, b: ox_left,
                            sx: sx, sy: sy, ox: ox_left, oy: oy_top};
        edge_op_next[1] = '{len: height, a: sx, b: ox_right,
                            sx: sx, sy: sy, ox: ox_right, oy: oy_top};
        // Top and bottom edges run along x; signs are folded into a and b.
        edge_op_next[2] = '{len: width, a: -sy, b: -oy_top,
                            sx: sx, sy: sy, ox: ox_left, oy: oy_top};
        edge_op_next[3] = '{len: width, a: -sy, b: -oy_bottom,
                            sx: sx, sy: sy, ox: ox_left, oy: oy_bottom};
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            edge_op_reg <= edge_op_next;
        end
    end

    // Stages 2 and 3: one unit for each rectangle edge.
    for (genvar e = 0; e < sri_pkg::NUM_EDGES; e++) begin : g_edge
        sri_edge_unit u_edge (
            .aclk    (aclk),
            .advance (advance),
            .op      (edge_op_reg[e]),
            .hit     (edge_hit[e])
        );
    end

    // Stage 4: output register holds the combined result until it is taken.
    always_ff @(posedge aclk) begin
        if (advance) begin
            hit_reg <= |edge_hit;
        end
    end

endmodule

// ===== hdl/sri_edge_unit.sv =====
// One rectangle edge against the segment: two register stages (products, then
// denominator and numerators) and the unit-interval test. Depends on sri_pkg.
module sri_edge_unit (
    input  logic              aclk,
    input  logic              advance,
    input  sri_pkg::edge_op_t op,
    output logic              hit
);

    sri_pkg::prod_t den_p_reg;
    sri_pkg::prod_t na_p_reg;
    sri_pkg::prod_t nb_p1_reg;
    sri_pkg::prod_t nb_p2_reg;
    sri_pkg::term_t den_reg;
    sri_pkg::term_t na_reg;
    sri_pkg::term_t nb_reg;

    // True when n / d lies in [0, 1]; a zero denominator never passes.
    function automatic logic in_unit(input sri_pkg::term_t n, input sri_pkg::term_t d);
        logic signed [sri_pkg::TERM_WIDTH:0] d_minus_n;
        logic signed [sri_pkg::TERM_WIDTH:0] n_minus_d;
        logic                                result;
        d_minus_n = {d[sri_pkg::TERM_WIDTH-1], d} - {n[sri_pkg::TERM_WIDTH-1], n};
        n_minus_d = {n[sri_pkg::TERM_WIDTH-1], n} - {d[sri_pkg::TERM_WIDTH-1], d};
        if (d > 0) begin
            result = (n >= 0) && (d_minus_n >= 0);
        end else if (d < 0) begin
            result = (n <= 0) && (n_minus_d >= 0);
        end else begin
            result = 1'b0;
        end
        return result;
    endfunction

    // Product stage: four signed multiplies.
    always_ff @(posedge aclk) begin
        if (advance) begin
            den_p_reg <= $signed(op.len) * $signed(op.a);
            na_p_reg  <= $signed(op.len) * $signed(op.b);
            nb_p1_reg <= $signed(op.sx) * $signed(op.oy);
            nb_p2_reg <= $signed(op.sy) * $signed(op.ox);
        end
    end

    // Combine stage: denominator and both numerators at full width.
    always_ff @(posedge aclk) begin
        if (advance) begin
            den_reg <= sri_pkg::term_t'(den_p_reg);
            na_reg  <= -sri_pkg::term_t'(na_p_reg);
            nb_reg  <= sri_pkg::term_t'(nb_p1_reg) - sri_pkg::term_t'(nb_p2_reg);
        end
    end

    // Both parameters must lie in the closed unit interval.
    assign hit = in_unit(na_reg, den_reg) && in_unit(nb_reg, den_reg);

endmodule

// ===== hdl/sri_checker.sv =====
// Port-level checks for segment_rect_intersect_core, attached by bind.
// Depends on sri_pkg.
module sri_checker (
    input logic            aclk,
    input logic            aresetn,
    input logic            s_valid,
    input logic            s_ready,
    input sri_pkg::coord_t s_seg_start_x,
    input sri_pkg::coord_t s_seg_start_y,
    input sri_pkg::coord_t s_seg_end_x,
    input sri_pkg::coord_t s_seg_end_y,
    input logic            m_valid,
    input logic            m_ready,
    input logic            m_hit
);

    logic                           degenerate;
    logic                           flowing;
    logic [sri_pkg::PIPE_DEPTH-1:0] ready_hist_reg;

    assign degenerate = (s_seg_start_x == s_seg_end_x) && (s_seg_start_y == s_seg_end_y);

    // Shift register of recent input-side ready values; s_ready is low while reset is held.
    always_ff @(posedge aclk) begin
        ready_hist_reg <= {ready_hist_reg[sri_pkg::PIPE_DEPTH-2:0], s_ready};
    end

    // Every bit of the history shows the input side ready: nothing was held back.
    assign flowing = &ready_hist_reg;

    // A waiting result item stays offered.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result item withdrawn before it was taken");

    // A waiting result item keeps its value.
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_hit))
        else $error("result item changed while stalled");

    // An empty output register never blocks the input side.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with no result pending");

    // Without stalls, each item comes out once, after it has passed through every pipeline stage.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        flowing |-> (m_valid == $past(s_valid, 4)))
        else $error("result item lost, repeated or mistimed");

    // A segment of zero length has zero denominators and never hits.
    a_point_segment: assert property (@(posedge aclk) disable iff (!aresetn)
        flowing && $past(s_valid && degenerate, 4) |-> !m_hit)
        else $error("zero-length segment reported a hit");

endmodule

bind segment_rect_intersect_core sri_checker u_sri_checker (.*);
